FILE: rtl/ccf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared widths, status codes and register indexes for the chase camera core.
// ----------------------------------------------------------------------------
package ccf_pkg;

    localparam int POS_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // serial multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // square root and divider widths
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int DVD_W  = 47;
    localparam int DSR_W  = 32;
    localparam int QUO_W  = 17;

    localparam logic [1:0] STATUS_UPDATED = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_LOST    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AIM_HEIGHT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET_Z = 3'd6;

endpackage

FILE: rtl/ccf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_if
// Valid/ready channels of the chase camera core: input word, result word and
// configuration write.
// ----------------------------------------------------------------------------
interface ccf_in_if import ccf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic                    target_present;
    logic                    target_dead;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic signed [POS_W-1:0] target_z;

    modport source (output valid, mode, target_present, target_dead,
                    target_x, target_y, target_z, input ready);
    modport sink   (input valid, mode, target_present, target_dead,
                    target_x, target_y, target_z, output ready);
endinterface

interface ccf_out_if import ccf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [POS_W-1:0] camera_x;
    logic signed [POS_W-1:0] camera_y;
    logic signed [POS_W-1:0] camera_z;
    logic signed [POS_W-1:0] look_x;
    logic signed [POS_W-1:0] look_y;
    logic signed [POS_W-1:0] look_z;

    modport source (output valid, status, camera_x, camera_y, camera_z,
                    look_x, look_y, look_z, input ready);
    modport sink   (input valid, status, camera_x, camera_y, camera_z,
                    look_x, look_y, look_z, output ready);
endinterface

interface ccf_cfg_if import ccf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ccf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ccf_mul import ccf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);
    localparam int ITER  = MUL_B_W;
    localparam int CNT_W = $clog2(ITER);

    logic [MUL_P_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_P_W-1:0] acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            a_reg    <= MUL_P_W'(a);
            b_reg    <= b;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg   <= {a_reg[MUL_P_W-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[MUL_B_W-1:1]};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

FILE: rtl/ccf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_sqrt
// Integer square root (floor), one result bit per cycle.
// ----------------------------------------------------------------------------
module ccf_sqrt import ccf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   op,
    output logic              done,
    output logic [ROOT_W-1:0] root
);
    localparam int ITER  = SQ_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic [SQ_W-1:0]  n_reg;
    logic [SQ_W-1:0]  r_reg;
    logic [SQ_W-1:0]  bit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SQ_W-1:0]  trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            r_reg    <= '0;
            bit_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            n_reg    <= op;
            r_reg    <= '0;
            bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];
endmodule

FILE: rtl/ccf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccf_div import ccf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quot
);
    localparam int ITER  = DVD_W;
    localparam int CNT_W = $clog2(ITER);

    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DSR_W:0]   trial;
    logic             qbit;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

FILE: rtl/chase_camera_follow_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chase_camera_follow_step_core
// Chase camera: follows a target one step per frame, Q24.8 positions.
// ----------------------------------------------------------------------------
// Usage:
//   target : input words (mode, presence, dead flag, target position).
//   result : one word per input: status, camera and look-at point after step.
//   cfg    : register writes (index, data), always ready; write only while idle.
// Steps: a start word passes through the evaluate, start and end states, an
//   ignored or lost word through the evaluate and end states. An update runs
//   three direction passes (two squarings, a square root and two divisions
//   each; a zero-length vector skips the divisions), four blend products,
//   two distance products and two offset products on the serial multiplier,
//   root and divider units.
// Throughput: one word at a time; the next word is taken the cycle after
//   the result is loaded, even while that result still waits.
// Reset: camera, look-at point and tracking clear; registers take defaults.
// Stall: a held result sits in the output register; the sequencer waits at
//   the end of the next word until that register is free.
// ----------------------------------------------------------------------------
module chase_camera_follow_step_core import ccf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ccf_in_if.sink     target,
    ccf_out_if.source  result,
    ccf_cfg_if.sink    cfg
);
    typedef enum logic [4:0] {
        S_IDLE, S_EVAL, S_START,
        S_H_ABS, S_H_SQX, S_H_SQZ, S_H_SQRT, S_H_DIVX, S_H_DIVZ, S_H_END,
        S_B_X1, S_B_X2, S_B_Z1, S_B_Z2,
        S_D_NEW, S_D_MIN, S_D_CLAMP,
        S_P_X, S_P_Z, S_FIN
    } state_t;

    // which direction the shared normalise sequence is working on
    typedef enum logic [1:0] {P_OLD, P_NEW, P_BLEND} pass_t;

    function automatic logic signed [35:0] sx36(input logic [31:0] v);
        return $signed({{4{v[31]}}, v});
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [16:0] mag18(input logic signed [17:0] v);
        logic [17:0] t;
        t = v[17] ? 18'(-v) : v;
        return t[16:0];
    endfunction

    // configuration
    logic [16:0] fw_reg;
    logic [30:0] min_reg;
    logic [30:0] max_reg;
    logic [31:0] aim_reg;
    logic [31:0] offx_reg;
    logic [31:0] offy_reg;
    logic [31:0] offz_reg;

    // state kept between words
    logic [31:0] camx_reg, camy_reg, camz_reg;
    logic [31:0] lookx_reg, looky_reg, lookz_reg;
    logic        tracking_reg;

    // sequencer
    state_t      state_reg;
    pass_t       pass_reg;
    logic        mode_reg, present_reg, dead_reg;
    logic [31:0] tx_reg, ty_reg, tz_reg;
    logic [1:0]  status_reg;
    logic [31:0] ry_reg;
    logic signed [35:0] height_reg;
    logic signed [33:0] hx_reg, hz_reg;
    logic [30:0] ax_reg, az_reg;
    logic        sgx_reg, sgz_reg, shift_reg;
    logic [63:0] sq_reg;
    logic [31:0] len_reg;
    logic [16:0] mx_reg, mz_reg;
    logic signed [17:0] ox_reg, oz_reg, nx_reg, nz_reg, bx_reg, ux_reg, uz_reg;
    logic [32:0] nlen_reg;
    logic signed [35:0] acc_reg;
    logic [50:0] dsum_reg;
    logic [34:0] draw_reg;
    logic [30:0] dist_reg;

    // unit controls
    logic               mul_start_reg, sqrt_start_reg, div_start_reg;
    logic [MUL_A_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic [SQ_W-1:0]    sqrt_op_reg;
    logic [DVD_W-1:0]   div_dvd_reg;
    logic [DSR_W-1:0]   div_dsr_reg;
    logic               mul_done, sqrt_done, div_done;
    logic [MUL_P_W-1:0] mul_p;
    logic [ROOT_W-1:0]  root;
    logic [QUO_W-1:0]   quot;

    // result register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_cx_reg, out_cy_reg, out_cz_reg;
    logic [31:0] out_lx_reg, out_ly_reg, out_lz_reg;

    ccf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_p)
    );

    ccf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start_reg),
        .op    (sqrt_op_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    ccf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .done     (div_done),
        .quot     (quot)
    );

    // weight saturates at one
    logic [16:0] w_eff, wc;
    assign w_eff = (fw_reg > 17'd65536) ? 17'd65536 : fw_reg;
    assign wc    = 17'(18'd65536 - {1'b0, w_eff});

    // magnitudes for normalising; halve both when either reaches 2^31
    logic [33:0] hx_abs, hz_abs;
    logic        shift_s;
    logic [30:0] ax_sh, az_sh;
    assign hx_abs  = hx_reg[33] ? 34'(-hx_reg) : hx_reg;
    assign hz_abs  = hz_reg[33] ? 34'(-hz_reg) : hz_reg;
    assign shift_s = (|hx_abs[33:31]) | (|hz_abs[33:31]);
    assign ax_sh   = shift_s ? hx_abs[31:1] : hx_abs[30:0];
    assign az_sh   = shift_s ? hz_abs[31:1] : hz_abs[30:0];

    logic signed [17:0] ux_calc, uz_calc;
    assign ux_calc = sgx_reg ? -$signed({1'b0, mx_reg}) : $signed({1'b0, mx_reg});
    assign uz_calc = sgz_reg ? -$signed({1'b0, mz_reg}) : $signed({1'b0, mz_reg});

    // signed blend term and truncating /65536
    logic               neg_sel;
    logic signed [35:0] mterm, bsum;
    logic [35:0]        bmag;
    logic [17:0]        bq;
    logic signed [17:0] bnew;
    always_comb
    begin
        case (state_reg)
            S_B_X1:  neg_sel = nx_reg[17];
            S_B_X2:  neg_sel = ox_reg[17];
            S_B_Z1:  neg_sel = nz_reg[17];
            S_B_Z2:  neg_sel = oz_reg[17];
            S_P_X:   neg_sel = ux_reg[17];
            S_P_Z:   neg_sel = uz_reg[17];
            default: neg_sel = 1'b0;
        endcase
    end
    assign mterm = neg_sel ? -$signed({2'b00, mul_p[33:0]}) : $signed({2'b00, mul_p[33:0]});
    assign bsum  = acc_reg + mterm;
    assign bmag  = bsum[35] ? 36'(-bsum) : bsum;
    assign bq    = bmag[33:16];
    assign bnew  = bsum[35] ? -$signed(bq) : $signed(bq);

    // horizontal offset from the target, truncated toward zero
    logic signed [35:0] poff;
    logic [31:0]        px_new;
    assign poff   = neg_sel ? -$signed({4'b0, mul_p[47:16]}) : $signed({4'b0, mul_p[47:16]});
    assign px_new = sat32(sx36((state_reg == S_P_X) ? tx_reg : tz_reg) + poff);

    // distance clamp: raise to min first, then lower to max
    logic [34:0] d_lo, d_hi;
    assign d_lo = (draw_reg < 35'(min_reg)) ? 35'(min_reg) : draw_reg;
    assign d_hi = (d_lo > 35'(max_reg)) ? 35'(max_reg) : d_lo;

    assign target.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= 17'd45875;
            min_reg  <= 31'd153600;
            max_reg  <= 31'd256000;
            aim_reg  <= 32'd20480;
            offx_reg <= 32'd0;
            offy_reg <= 32'd38400;
            offz_reg <= 32'hFFFC_E000;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FOLLOW_WEIGHT:  fw_reg   <= cfg.data[16:0];
                REG_MIN_DISTANCE:   min_reg  <= cfg.data[30:0];
                REG_MAX_DISTANCE:   max_reg  <= cfg.data[30:0];
                REG_AIM_HEIGHT:     aim_reg  <= cfg.data;
                REG_START_OFFSET_X: offx_reg <= cfg.data;
                REG_START_OFFSET_Y: offy_reg <= cfg.data;
                REG_START_OFFSET_Z: offz_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_reg       <= P_OLD;
            camx_reg       <= '0;
            camy_reg       <= '0;
            camz_reg       <= '0;
            lookx_reg      <= '0;
            looky_reg      <= '0;
            lookz_reg      <= '0;
            tracking_reg   <= 1'b0;
            mode_reg       <= 1'b0;
            present_reg    <= 1'b0;
            dead_reg       <= 1'b0;
            tx_reg         <= '0;
            ty_reg         <= '0;
            tz_reg         <= '0;
            status_reg     <= STATUS_UPDATED;
            ry_reg         <= '0;
            height_reg     <= '0;
            hx_reg         <= '0;
            hz_reg         <= '0;
            ax_reg         <= '0;
            az_reg         <= '0;
            sgx_reg        <= 1'b0;
            sgz_reg        <= 1'b0;
            shift_reg      <= 1'b0;
            sq_reg         <= '0;
            len_reg        <= '0;
            mx_reg         <= '0;
            mz_reg         <= '0;
            ox_reg         <= '0;
            oz_reg         <= '0;
            nx_reg         <= '0;
            nz_reg         <= '0;
            bx_reg         <= '0;
            ux_reg         <= '0;
            uz_reg         <= '0;
            nlen_reg       <= '0;
            acc_reg        <= '0;
            dsum_reg       <= '0;
            draw_reg       <= '0;
            dist_reg       <= '0;
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            sqrt_op_reg    <= '0;
            div_dvd_reg    <= '0;
            div_dsr_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_UPDATED;
            out_cx_reg     <= '0;
            out_cy_reg     <= '0;
            out_cz_reg     <= '0;
            out_lx_reg     <= '0;
            out_ly_reg     <= '0;
            out_lz_reg     <= '0;
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (target.valid)
                    begin
                        mode_reg    <= target.mode;
                        present_reg <= target.target_present;
                        dead_reg    <= target.target_dead;
                        tx_reg      <= target.target_x;
                        ty_reg      <= target.target_y;
                        tz_reg      <= target.target_z;
                        state_reg   <= S_EVAL;
                    end
                end

                S_EVAL:
                begin
                    ry_reg     <= sat32(sx36(ty_reg) + sx36(aim_reg));
                    height_reg <= sx36(camy_reg) - sx36(looky_reg);
                    status_reg <= STATUS_UPDATED;
                    if (!present_reg)
                    begin
                        status_reg <= STATUS_IGNORED;
                        state_reg  <= S_FIN;
                    end
                    else if (!mode_reg)
                    begin
                        lookx_reg    <= tx_reg;
                        looky_reg    <= sat32(sx36(ty_reg) + sx36(aim_reg));
                        lookz_reg    <= tz_reg;
                        tracking_reg <= 1'b1;
                        state_reg    <= S_START;
                    end
                    else if (!tracking_reg)
                    begin
                        status_reg <= STATUS_IGNORED;
                        state_reg  <= S_FIN;
                    end
                    else if (dead_reg)
                    begin
                        tracking_reg <= 1'b0;
                        status_reg   <= STATUS_LOST;
                        state_reg    <= S_FIN;
                    end
                    else
                    begin
                        hx_reg    <= 34'(sx36(camx_reg) - sx36(lookx_reg));
                        hz_reg    <= 34'(sx36(camz_reg) - sx36(lookz_reg));
                        pass_reg  <= P_OLD;
                        state_reg <= S_H_ABS;
                    end
                end

                S_START:
                begin
                    camx_reg  <= sat32(sx36(lookx_reg) + sx36(offx_reg));
                    camy_reg  <= sat32(sx36(looky_reg) + sx36(offy_reg));
                    camz_reg  <= sat32(sx36(lookz_reg) + sx36(offz_reg));
                    state_reg <= S_FIN;
                end

                S_H_ABS:
                begin
                    ax_reg        <= ax_sh;
                    az_reg        <= az_sh;
                    sgx_reg       <= hx_reg[33];
                    sgz_reg       <= hz_reg[33];
                    shift_reg     <= shift_s;
                    mul_a_reg     <= MUL_A_W'(ax_sh);
                    mul_b_reg     <= MUL_B_W'(ax_sh);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_H_SQX;
                end

                S_H_SQX:
                begin
                    if (mul_done)
                    begin
                        sq_reg        <= mul_p[63:0];
                        mul_a_reg     <= MUL_A_W'(az_reg);
                        mul_b_reg     <= MUL_B_W'(az_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_H_SQZ;
                    end
                end

                S_H_SQZ:
                begin
                    if (mul_done)
                    begin
                        sqrt_op_reg    <= sq_reg + mul_p[63:0];
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= S_H_SQRT;
                    end
                end

                S_H_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        len_reg <= root;
                        if (root == '0)
                        begin
                            // zero-length vector normalises to zero
                            mx_reg    <= '0;
                            mz_reg    <= '0;
                            state_reg <= S_H_END;
                        end
                        else
                        begin
                            div_dvd_reg   <= {ax_reg, 16'b0};
                            div_dsr_reg   <= root;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_H_DIVX;
                        end
                    end
                end

                S_H_DIVX:
                begin
                    if (div_done)
                    begin
                        mx_reg        <= quot;
                        div_dvd_reg   <= {az_reg, 16'b0};
                        div_start_reg <= 1'b1;
                        state_reg     <= S_H_DIVZ;
                    end
                end

                S_H_DIVZ:
                begin
                    if (div_done)
                    begin
                        mz_reg    <= quot;
                        state_reg <= S_H_END;
                    end
                end

                S_H_END:
                begin
                    case (pass_reg)
                        P_OLD:
                        begin
                            ox_reg    <= ux_calc;
                            oz_reg    <= uz_calc;
                            hx_reg    <= 34'(sx36(camx_reg) - sx36(tx_reg));
                            hz_reg    <= 34'(sx36(camz_reg) - sx36(tz_reg));
                            pass_reg  <= P_NEW;
                            state_reg <= S_H_ABS;
                        end
                        P_NEW:
                        begin
                            nx_reg        <= ux_calc;
                            nz_reg        <= uz_calc;
                            nlen_reg      <= shift_reg ? {len_reg, 1'b0} : {1'b0, len_reg};
                            mul_a_reg     <= MUL_A_W'(mx_reg);
                            mul_b_reg     <= MUL_B_W'(w_eff);
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_B_X1;
                        end
                        default:
                        begin
                            ux_reg        <= ux_calc;
                            uz_reg        <= uz_calc;
                            mul_a_reg     <= nlen_reg;
                            mul_b_reg     <= MUL_B_W'(w_eff);
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_D_NEW;
                        end
                    endcase
                end

                S_B_X1:
                begin
                    if (mul_done)
                    begin
                        acc_reg       <= mterm;
                        mul_a_reg     <= MUL_A_W'(mag18(ox_reg));
                        mul_b_reg     <= MUL_B_W'(wc);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_B_X2;
                    end
                end

                S_B_X2:
                begin
                    if (mul_done)
                    begin
                        bx_reg        <= bnew;
                        mul_a_reg     <= MUL_A_W'(mag18(nz_reg));
                        mul_b_reg     <= MUL_B_W'(w_eff);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_B_Z1;
                    end
                end

                S_B_Z1:
                begin
                    if (mul_done)
                    begin
                        acc_reg       <= mterm;
                        mul_a_reg     <= MUL_A_W'(mag18(oz_reg));
                        mul_b_reg     <= MUL_B_W'(wc);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_B_Z2;
                    end
                end

                S_B_Z2:
                begin
                    if (mul_done)
                    begin
                        hx_reg    <= 34'(bx_reg);
                        hz_reg    <= 34'(bnew);
                        pass_reg  <= P_BLEND;
                        state_reg <= S_H_ABS;
                    end
                end

                S_D_NEW:
                begin
                    if (mul_done)
                    begin
                        dsum_reg      <= mul_p[50:0];
                        mul_a_reg     <= MUL_A_W'(min_reg);
                        mul_b_reg     <= MUL_B_W'(wc);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_D_MIN;
                    end
                end

                S_D_MIN:
                begin
                    if (mul_done)
                    begin
                        draw_reg  <= 35'((dsum_reg + mul_p[50:0]) >> 16);
                        state_reg <= S_D_CLAMP;
                    end
                end

                S_D_CLAMP:
                begin
                    dist_reg      <= d_hi[30:0];
                    mul_a_reg     <= MUL_A_W'(d_hi[30:0]);
                    mul_b_reg     <= MUL_B_W'(mag18(ux_reg));
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_P_X;
                end

                S_P_X:
                begin
                    if (mul_done)
                    begin
                        camx_reg      <= px_new;
                        lookx_reg     <= tx_reg;
                        mul_a_reg     <= MUL_A_W'(dist_reg);
                        mul_b_reg     <= MUL_B_W'(mag18(uz_reg));
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_P_Z;
                    end
                end

                S_P_Z:
                begin
                    if (mul_done)
                    begin
                        camz_reg  <= px_new;
                        lookz_reg <= tz_reg;
                        camy_reg  <= sat32(sx36(ry_reg) + height_reg);
                        looky_reg <= ry_reg;
                        state_reg <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_cx_reg     <= camx_reg;
                        out_cy_reg     <= camy_reg;
                        out_cz_reg     <= camz_reg;
                        out_lx_reg     <= lookx_reg;
                        out_ly_reg     <= looky_reg;
                        out_lz_reg     <= lookz_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.camera_x = out_cx_reg;
    assign result.camera_y = out_cy_reg;
    assign result.camera_z = out_cz_reg;
    assign result.look_x   = out_lx_reg;
    assign result.look_y   = out_ly_reg;
    assign result.look_z   = out_lz_reg;

`ifndef SYNTHESIS
    // leaving the end state always leaves a word in the output register
    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && (!out_valid_reg || result.ready)) |=> result.valid)
        else $error("result word not loaded at end of step");

    // no arithmetic unit may finish while the sequencer sits idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!mul_done && !sqrt_done && !div_done))
        else $error("unit completion outside a step");

    // the clamped distance never exceeds the maximum while it is used
    a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_X || state_reg == S_P_Z) |-> (dist_reg <= max_reg))
        else $error("follow distance above maximum");
`endif
endmodule
